FILE: design/lphs_pkg.sv
// ----------------------------------------------------------------------------
// lphs_pkg
// Shared types and constants for the linear probing hash set unit.
// ----------------------------------------------------------------------------
package lphs_pkg;

  localparam int KEY_W  = 31;
  localparam int FUNC_W = 2;
  localparam int CNT_W  = 11;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ERASE  = 2'd2;
  // spare selector, behaves as a lookup
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_PROBE,
    ST_OUT
  } state_t;

  // Modulo unit sequencer
  typedef enum logic [1:0] {
    MOD_IDLE,
    MOD_QUOT,
    MOD_BACK,
    MOD_FIX
  } mod_state_t;

endpackage

FILE: design/lphs_mod.sv
// ----------------------------------------------------------------------------
// lphs_mod
// Key modulo table size by reciprocal multiplication on one shared multiplier.
// ----------------------------------------------------------------------------
module lphs_mod #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [lphs_pkg::KEY_W-1:0]   key,
  output logic                         done,
  output logic [$clog2(TABLE_SIZE)-1:0] rem
);

  localparam int IDX_W = $clog2(TABLE_SIZE);
  localparam int KW    = lphs_pkg::KEY_W;
  localparam int PW    = 2 * KW;
  // floor(2^31 / TABLE_SIZE): the quotient estimate is never more than one short
  localparam logic [KW-1:0] RECIP   = KW'((64'd1 << KW) / TABLE_SIZE);
  localparam logic [KW-1:0] MODULUS = KW'(TABLE_SIZE);

  lphs_pkg::mod_state_t state_r, state_nxt;
  logic                 done_r, done_nxt;
  logic [KW-1:0]        key_r, key_nxt;
  logic [PW-1:0]        prod_r, prod_nxt;
  logic [IDX_W-1:0]     rem_r, rem_nxt;
  logic [KW-1:0]        mul_a, mul_b;
  logic [PW-1:0]        mul_p;
  logic [KW-1:0]        diff;

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lphs_pkg::MOD_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    key_r  <= key_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    key_nxt   = key_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    mul_a     = key_r;
    mul_b     = RECIP;
    diff      = key_r - prod_r[KW-1:0];

    case (state_r)
      lphs_pkg::MOD_IDLE: begin
        if (start) begin
          key_nxt   = key;
          state_nxt = lphs_pkg::MOD_QUOT;
        end
      end

      lphs_pkg::MOD_QUOT: begin
        prod_nxt  = mul_p;
        state_nxt = lphs_pkg::MOD_BACK;
      end

      lphs_pkg::MOD_BACK: begin
        // multiply the quotient estimate back by the table size
        mul_a     = prod_r[PW-1:KW];
        mul_b     = MODULUS;
        prod_nxt  = mul_p;
        state_nxt = lphs_pkg::MOD_FIX;
      end

      lphs_pkg::MOD_FIX: begin
        // remainder is below twice the modulus: subtract once if needed
        if (diff >= MODULUS) begin
          diff = diff - MODULUS;
        end
        rem_nxt   = diff[IDX_W-1:0];
        done_nxt  = 1'b1;
        state_nxt = lphs_pkg::MOD_IDLE;
      end

      default: begin
        state_nxt = lphs_pkg::MOD_IDLE;
      end
    endcase
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: design/linear_probe_hash_set_unit.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_set_unit
// Open-addressing hash set with linear probing and tombstones.
// ----------------------------------------------------------------------------
// Flow: for a power-of-two TABLE_SIZE the home slot is the low key bits;
//   otherwise the modulo unit forms a quotient estimate, multiplies it back
//   and corrects the remainder first. One item is handled at a time; the
//   read port probes one slot per cycle while a search runs.
// Reset: a clearing pass empties every slot; in_tready stays low until it
//   is done. The live count resets to zero.
module linear_probe_hash_set_unit #(
  parameter int TABLE_SIZE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] key, [31] zero
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [0] found, [1] status, [12:2] live_count
);

  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int KEY_W  = lphs_pkg::KEY_W;
  localparam int CNT_W  = lphs_pkg::CNT_W;
  localparam int FUNC_W = lphs_pkg::FUNC_W;
  localparam int ENT_W  = KEY_W + 2;
  localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

  lphs_pkg::state_t   state_r, state_nxt;
  logic [FUNC_W-1:0]  func_r, func_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   n_r, n_nxt;
  logic [IDX_W-1:0]   clr_r, clr_nxt;
  logic               have_free_r, have_free_nxt;
  logic [IDX_W-1:0]   free_r, free_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               found_r, found_nxt;
  logic               status_r, status_nxt;

  // Slot memory entry: {used, tomb, key}
  logic [ENT_W-1:0]   slot_mem [TABLE_SIZE];
  logic [ENT_W-1:0]   rd_data_r;
  logic               mem_we, mem_re;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  logic [ENT_W-1:0]   mem_wdata;

  logic               slot_used, slot_tomb, slot_hit, probe_stop;
  logic [IDX_W-1:0]   step_idx;
  logic [IDX_W-1:0]   mod_rem;
  logic               mod_start, mod_done;

  lphs_mod #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .key   (in_tdata[KEY_W-1:0]),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= slot_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lphs_pkg::ST_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
    end
    func_r      <= func_nxt;
    key_r       <= key_nxt;
    idx_r       <= idx_nxt;
    n_r         <= n_nxt;
    have_free_r <= have_free_nxt;
    free_r      <= free_nxt;
    found_r     <= found_nxt;
    status_r    <= status_nxt;
  end

  assign slot_used = rd_data_r[ENT_W-1];
  assign slot_tomb = rd_data_r[ENT_W-2];
  assign step_idx  = (idx_r == LAST_IDX) ? '0 : idx_r + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    clr_nxt       = clr_r;
    have_free_nxt = have_free_r;
    free_nxt      = free_r;
    cnt_nxt       = cnt_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    mem_we        = 1'b0;
    mem_waddr     = clr_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = idx_r;
    mod_start     = 1'b0;
    in_tready     = 1'b0;
    slot_hit      = 1'b0;
    probe_stop    = 1'b0;

    case (state_r)
      lphs_pkg::ST_CLEAR: begin
        mem_we  = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = lphs_pkg::ST_IDLE;
        end
      end

      lphs_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          func_nxt      = in_tuser[FUNC_W-1:0];
          key_nxt       = in_tdata[KEY_W-1:0];
          n_nxt         = '0;
          have_free_nxt = 1'b0;
          free_nxt      = '0;
          if (IS_POW2) begin
            idx_nxt   = in_tdata[IDX_W-1:0];
            mem_re    = 1'b1;
            mem_raddr = in_tdata[IDX_W-1:0];
            state_nxt = lphs_pkg::ST_PROBE;
          end else begin
            mod_start = 1'b1;
            state_nxt = lphs_pkg::ST_MOD;
          end
        end
      end

      lphs_pkg::ST_MOD: begin
        if (mod_done) begin
          idx_nxt   = mod_rem;
          mem_re    = 1'b1;
          mem_raddr = mod_rem;
          state_nxt = lphs_pkg::ST_PROBE;
        end
      end

      lphs_pkg::ST_PROBE: begin
        // note the first free slot; tombstones do not end the search
        if (!slot_used) begin
          probe_stop = 1'b1;
          if (!have_free_r) begin
            have_free_nxt = 1'b1;
            free_nxt      = idx_r;
          end
        end else if (slot_tomb) begin
          if (!have_free_r) begin
            have_free_nxt = 1'b1;
            free_nxt      = idx_r;
          end
        end else if (rd_data_r[KEY_W-1:0] == key_r) begin
          slot_hit   = 1'b1;
          probe_stop = 1'b1;
        end
        if (n_r == LAST_IDX) begin
          probe_stop = 1'b1;
        end

        if (probe_stop) begin
          found_nxt  = slot_hit;
          status_nxt = lphs_pkg::STATUS_OK;
          state_nxt  = lphs_pkg::ST_OUT;
          case (func_r)
            lphs_pkg::FUNC_INSERT: begin
              if (!slot_hit) begin
                if (have_free_nxt) begin
                  mem_we    = 1'b1;
                  mem_waddr = free_nxt;
                  mem_wdata = {1'b1, 1'b0, key_r};
                  cnt_nxt   = cnt_r + 1'b1;
                end else begin
                  status_nxt = lphs_pkg::STATUS_FULL;
                end
              end
            end
            lphs_pkg::FUNC_ERASE: begin
              if (slot_hit) begin
                mem_we    = 1'b1;
                mem_waddr = idx_r;
                mem_wdata = {1'b1, 1'b1, key_r};
                cnt_nxt   = cnt_r - 1'b1;
              end
            end
            default: begin
            end
          endcase
        end else begin
          // advance to the next slot, wrapping at the end of the table
          idx_nxt   = step_idx;
          n_nxt     = n_r + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = step_idx;
        end
      end

      lphs_pkg::ST_OUT: begin
        if (out_tready) begin
          state_nxt = lphs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = lphs_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = (state_r == lphs_pkg::ST_OUT);
  assign out_tdata  = {3'b000, cnt_r, status_r, found_r};

endmodule

FILE: design/lphs_checker.sv
// ----------------------------------------------------------------------------
// lphs_checker
// Port-level checks on the hash set unit, bound to the top level.
// ----------------------------------------------------------------------------
module lphs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // one item in flight: never ready while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (!in_tready && !out_tvalid))
    else $error("unit not busy after input beat");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> !out_tvalid)
    else $error("result repeated");

  a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[1]) |-> !out_tdata[0])
    else $error("refused insert reports key found");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind linear_probe_hash_set_unit lphs_checker u_lphs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for linear_probe_hash_set_unit
// Streams insert, lookup and erase beats into the hash set and checks every
// result against a local model of the slot table. A directed
// opening covers collisions, wrap-around, tombstones and duplicates; random
// traffic then works a clustered key pool, and a final phase fills the table
// to refuse inserts when full.
// ----------------------------------------------------------------------------
module testbench;

  localparam int FUNC_W    = lphs_pkg::FUNC_W;
  localparam int KEY_W     = lphs_pkg::KEY_W;
  localparam int CNT_W     = lphs_pkg::CNT_W;
  localparam int SLOTS     = 1024;
  localparam int LIMIT     = 10_000_000;
  localparam int IDLE_PCT  = 35;
  localparam int HOLD_LEN  = 400;
  localparam int TAIL_WAIT = 1100;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
  } set_op_t;

  typedef struct {
    logic             found;
    logic             status;
    logic [CNT_W-1:0] count;
  } set_resp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [30:0] key, [31] zero
  logic [1:0]  in_tuser = '0;   // [1:0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [0] found, [1] status, [12:2] live_count

  linear_probe_hash_set_unit #(.TABLE_SIZE(SLOTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Local copy of the slot table
  logic [KEY_W-1:0] slot_key_m [SLOTS];
  bit               slot_used_m [SLOTS];
  bit               slot_tomb_m [SLOTS];
  logic [CNT_W-1:0] live_m = '0;

  set_op_t   op_q[$];
  set_resp_t resp_q[$];

  logic in_fire = 1'b0;
  int   n_sent = 0;
  int   n_recv = 0;
  int   n_err = 0;
  int   cyc = 0;
  int   hold_cnt = 0;
  bit   hold_done = 1'b0;

  wire calm_in  = (n_sent >= 300) && (n_sent < 450);
  wire calm_out = (n_recv >= 300) && (n_recv < 450);

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic set_resp_t hash_set_apply(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key);
    int unsigned idx;
    int unsigned hit_idx;
    int unsigned free_idx;
    bit          have_free;
    bit          present;
    set_resp_t   r;
    idx       = key % SLOTS;
    hit_idx   = 0;
    free_idx  = 0;
    have_free = 1'b0;
    present   = 1'b0;
    // walk until an empty slot or one full lap; tombstones do not stop it
    for (int n = 0; n < SLOTS; n++) begin
      if (!slot_used_m[idx]) begin
        if (!have_free) begin
          have_free = 1'b1;
          free_idx  = idx;
        end
        break;
      end
      if (slot_tomb_m[idx]) begin
        if (!have_free) begin
          have_free = 1'b1;
          free_idx  = idx;
        end
      end else if (slot_key_m[idx] == key) begin
        present = 1'b1;
        hit_idx = idx;
        break;
      end
      idx = (idx + 1) % SLOTS;
    end
    r.status = lphs_pkg::STATUS_OK;
    if (func == lphs_pkg::FUNC_INSERT) begin
      if (!present) begin
        if (have_free) begin
          slot_key_m[free_idx]  = key;
          slot_used_m[free_idx] = 1'b1;
          slot_tomb_m[free_idx] = 1'b0;
          live_m                = live_m + 1'b1;
        end else begin
          r.status = lphs_pkg::STATUS_FULL;
        end
      end
    end else if (func == lphs_pkg::FUNC_ERASE) begin
      if (present) begin
        slot_tomb_m[hit_idx] = 1'b1;
        live_m               = live_m - 1'b1;
      end
    end
    r.found = present;
    r.count = live_m;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (n_err < 50)
      $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h", n_recv, what, got, want);
    n_err++;
  endtask

  task automatic push_op(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key);
    set_op_t op;
    op.func = func;
    op.key  = key;
    op_q.push_back(op);
  endtask

  // Sample after the driver's update has settled
  task automatic wait_drained();
    while (op_q.size() != 0 || in_tvalid || resp_q.size() != 0)
      @(posedge clk);
  endtask

  // Mostly a clustered pool of keys homed on the low slots, some full-range
  task automatic push_random_ops(int count);
    int               r;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 40)      func = lphs_pkg::FUNC_INSERT;
      else if (r < 68) func = lphs_pkg::FUNC_LOOKUP;
      else if (r < 93) func = lphs_pkg::FUNC_ERASE;
      else             func = lphs_pkg::FUNC_UNUSED;
      if ($urandom_range(9) == 0)
        key = KEY_W'($urandom);
      else
        key = KEY_W'($urandom_range(127) + SLOTS * $urandom_range(3));
      push_op(func, key);
    end
  endtask

  // Driver: present a new beat once the previous one is taken
  always @(negedge clk) begin
    set_op_t cur;
    if (rst_n && (!in_tvalid || in_fire)) begin
      if (op_q.size() != 0 && (calm_in || $urandom_range(99) >= IDLE_PCT)) begin
        cur       = op_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {1'b0, cur.key};
        in_tuser  <= cur.func;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt   <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (n_recv == 700 && !hold_done) begin
      hold_done  <= 1'b1;
      hold_cnt   <= HOLD_LEN;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm_out || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Monitor: check results, then record the beat taken at this edge
  always @(posedge clk) begin
    set_resp_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (resp_q.size() == 0) begin
          report_mismatch("result with none pending", int'(out_tdata), 0);
        end else begin
          want = resp_q.pop_front();
          if (out_tdata[0] !== want.found)
            report_mismatch("found", int'(out_tdata[0]), int'(want.found));
          if (out_tdata[1] !== want.status)
            report_mismatch("status", int'(out_tdata[1]), int'(want.status));
          if (out_tdata[12:2] !== want.count)
            report_mismatch("live_count", int'(out_tdata[12:2]), int'(want.count));
        end
        n_recv <= n_recv + 1;
      end
      if (in_tvalid && in_tready) begin
        resp_q.push_back(hash_set_apply(in_tuser, in_tdata[KEY_W-1:0]));
        n_sent <= n_sent + 1;
      end
    end
    in_fire <= rst_n && in_tvalid && in_tready;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("FAIL linear_probe_hash_set_unit");
      $finish;
    end
  end

  initial begin
    int               needed;
    int               r;
    logic [KEY_W-1:0] key;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // collisions, wrap at the table end, tombstones, duplicates, spare selector
    push_op(lphs_pkg::FUNC_INSERT, 31'd0);
    push_op(lphs_pkg::FUNC_INSERT, 31'h7FFF_FFFF);
    push_op(lphs_pkg::FUNC_LOOKUP, 31'd0);
    push_op(lphs_pkg::FUNC_LOOKUP, 31'h7FFF_FFFF);
    push_op(lphs_pkg::FUNC_INSERT, 31'd0);
    push_op(lphs_pkg::FUNC_ERASE,  31'd5);
    push_op(lphs_pkg::FUNC_INSERT, 31'd1024);
    push_op(lphs_pkg::FUNC_INSERT, 31'd2047);
    push_op(lphs_pkg::FUNC_ERASE,  31'd0);
    push_op(lphs_pkg::FUNC_LOOKUP, 31'd1024);
    push_op(lphs_pkg::FUNC_LOOKUP, 31'd0);
    push_op(lphs_pkg::FUNC_INSERT, 31'd2048);
    push_op(lphs_pkg::FUNC_INSERT, 31'd1024);
    push_op(lphs_pkg::FUNC_UNUSED, 31'd1024);
    push_op(lphs_pkg::FUNC_UNUSED, 31'd7);
    push_op(lphs_pkg::FUNC_ERASE,  31'd1024);
    push_op(lphs_pkg::FUNC_ERASE,  31'd1024);
    push_op(lphs_pkg::FUNC_LOOKUP, 31'd2047);
    push_op(lphs_pkg::FUNC_INSERT, 31'd1024);
    push_op(lphs_pkg::FUNC_ERASE,  31'h7FFF_FFFF);
    push_op(lphs_pkg::FUNC_INSERT, 31'h5555_5555);
    push_op(lphs_pkg::FUNC_INSERT, 31'h2AAA_AAAA);
    push_op(lphs_pkg::FUNC_ERASE,  31'd2048);
    wait_drained();

    push_random_ops(500);
    wait_drained();
    push_random_ops(500);
    wait_drained();

    // fill every slot with fresh keys; the last few are refused
    needed = SLOTS - int'(live_m) + 4;
    for (int s = 0; s < needed; s++)
      push_op(lphs_pkg::FUNC_INSERT, KEY_W'(32'h4000_0000 + s));
    wait_drained();

    // full table: refused inserts, long lookups, erase and refill
    for (int i = 0; i < 60; i++) begin
      r = $urandom_range(99);
      if (r < 30) begin
        push_op(lphs_pkg::FUNC_INSERT, KEY_W'(32'h6000_0000 + i));
      end else if (r < 55) begin
        key = KEY_W'($urandom);
        push_op(lphs_pkg::FUNC_LOOKUP, key);
      end else if (r < 80) begin
        push_op(lphs_pkg::FUNC_ERASE, KEY_W'(32'h4000_0000 + $urandom_range(SLOTS - 1)));
      end else begin
        push_op(lphs_pkg::FUNC_LOOKUP, KEY_W'(32'h4000_0000 + $urandom_range(SLOTS - 1)));
      end
    end
    wait_drained();

    repeat (TAIL_WAIT) @(negedge clk);
    if (n_err == 0) begin
      $display("PASS linear_probe_hash_set_unit");
    end else begin
      $display("FAIL linear_probe_hash_set_unit");
    end
    $finish;
  end

endmodule

FILE: files.f
design/lphs_pkg.sv
design/lphs_mod.sv
design/linear_probe_hash_set_unit.sv
design/lphs_checker.sv
tb/sv/testbench.sv
